/* sv/set_assoc_cache_nru_unit_defines.svh */
// ----------------------------------------------------------------------------
// Set-associative cache NRU unit: assertion macros
// Shared property templates for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_NRU_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_NRU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAC_NRU_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAC_NRU_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sac_nru_pkg.sv */
// ----------------------------------------------------------------------------
// Set-associative cache NRU unit: package
// Geometry constants, config register codes and line storage types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sac_nru_pkg;

	localparam int ADDR_BITS = 32;
	localparam int NUM_SETS  = 64;
	localparam int NUM_WAYS  = 4;

	localparam int IDX_W  = $clog2(NUM_SETS);
	localparam int WAY_W  = $clog2(NUM_WAYS);
	localparam int TAG_W  = ADDR_BITS;
	localparam int WIDE_W = 2 * ADDR_BITS;
	localparam int SHAMT_W = $clog2(WIDE_W);

	localparam int CNT_W = 24;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// config port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_W-1:0] OFFSET_BITS_RST = CFG_W'(2);
	localparam logic [CFG_W-1:0] INDEX_LOW_RST   = CFG_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 1'b0,
		CFG_INDEX_LOW   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic             nru;
	} way_entry_t;

	typedef way_entry_t [NUM_WAYS-1:0] set_line_t;

	localparam int LINE_W = $bits(set_line_t);

endpackage

/* sv/sac_nru_if.sv */
// ----------------------------------------------------------------------------
// Set-associative cache NRU unit: channel interfaces
// Request channel (opcode, address) and response channel (lookup result).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sac_nru_in_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic [sac_nru_pkg::ADDR_BITS-1:0]   address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface sac_nru_out_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic [sac_nru_pkg::WAY_W-1:0]     way;
	logic [sac_nru_pkg::IDX_W-1:0]     set_index;
	logic [sac_nru_pkg::CNT_W-1:0]     miss_total;
	logic [sac_nru_pkg::CNT_W-1:0]     hit_total;

	modport source (output valid, output hit, output way, output set_index,
		output miss_total, output hit_total, input ready);
	modport sink   (input valid, input hit, input way, input set_index,
		input miss_total, input hit_total, output ready);
endinterface

/* sv/sac_nru_ram.sv */
// ----------------------------------------------------------------------------
// Set-associative cache NRU unit: generic RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sac_nru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns old data on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/set_assoc_cache_nru_unit.sv */
// ----------------------------------------------------------------------------
// Set-associative cache NRU unit: top level
// Tag lookup for a 64-set, 4-way cache with not-recently-used replacement.
//
// req: requests carry opcode (access or clear-all) and a 32-bit byte address.
// rsp: one response per request: hit, way hit or filled, set, and the
//      saturating miss and hit totals after that request.
// cfg: cfg_we/cfg_index/cfg_wdata write offset_bits (0) and index_low (1);
//      write only while no request is in flight.
// Path: a request goes through the tag RAM read, then the response register,
// before its response can be taken.
// Throughput: one request per cycle unless a response is held up. The tag RAM
// reads a set at acceptance and writes it back as its lookup ends; a request
// back-to-back on the same set takes the line from a forwarding register.
// Reset: lines read as invalid with NRU set, via one written flag per set in
// flops; a clear request resets these flags at once, so there is no sweep.
// Stall: while a response waits and rsp.ready is low the lookup stage holds
// and req.ready drops; the tag RAM re-reads the held set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_nru_unit_defines.svh"

module set_assoc_cache_nru_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sac_nru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sac_nru_pkg::CFG_W-1:0]         cfg_wdata,
	sac_nru_in_if.sink                            req,
	sac_nru_out_if.source                         rsp
);

	localparam int IDX_W    = sac_nru_pkg::IDX_W;
	localparam int WAY_W    = sac_nru_pkg::WAY_W;
	localparam int TAG_W    = sac_nru_pkg::TAG_W;
	localparam int CNT_W    = sac_nru_pkg::CNT_W;
	localparam int WIDE_W   = sac_nru_pkg::WIDE_W;
	localparam int SHAMT_W  = sac_nru_pkg::SHAMT_W;
	localparam int NUM_WAYS = sac_nru_pkg::NUM_WAYS;
	localparam int NUM_SETS = sac_nru_pkg::NUM_SETS;

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic [sac_nru_pkg::CFG_W-1:0] offset_bits_q;
	logic [sac_nru_pkg::CFG_W-1:0] index_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= sac_nru_pkg::OFFSET_BITS_RST;
			index_low_q   <= sac_nru_pkg::INDEX_LOW_RST;
		end else if (cfg_we) begin
			case (sac_nru_pkg::cfg_reg_t'(cfg_index))
				sac_nru_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata;
				sac_nru_pkg::CFG_INDEX_LOW:   index_low_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Address split: set field and compacted tag
	// ------------------------------------------------------------------
	// The index field is squeezed out of the address first; the tag is then
	// that compacted word shifted down by the offset position mapped into it.
	logic [WIDE_W-1:0]  addr_wide;
	logic [SHAMT_W-1:0] idx_lo;
	logic [SHAMT_W-1:0] idx_end;
	logic [SHAMT_W-1:0] offs;
	logic [SHAMT_W-1:0] tag_start;
	logic [WIDE_W-1:0]  low_mask;
	logic [WIDE_W-1:0]  squeezed;
	logic [WIDE_W-1:0]  tag_wide;
	logic [WIDE_W-1:0]  set_wide;
	logic [IDX_W-1:0]   set_in;
	logic [TAG_W-1:0]   tag_in;

	always_comb begin
		addr_wide = WIDE_W'(req.address);
		idx_lo    = SHAMT_W'(index_low_q);
		idx_end   = idx_lo + SHAMT_W'(IDX_W);
		offs      = SHAMT_W'(offset_bits_q);
		low_mask  = (WIDE_W'(1) << idx_lo) - WIDE_W'(1);
		squeezed  = (addr_wide & low_mask) | ((addr_wide >> idx_end) << idx_lo);
		if (offs <= idx_lo) begin
			tag_start = offs;
		end else if (offs >= idx_end) begin
			tag_start = offs - SHAMT_W'(IDX_W);
		end else begin
			tag_start = idx_lo;
		end
		tag_wide = squeezed >> tag_start;
		tag_in   = tag_wide[TAG_W-1:0];
		set_wide = addr_wide >> idx_lo;
		set_in   = set_wide[IDX_W-1:0];
	end

	// ------------------------------------------------------------------
	// Lookup stage and handshake
	// ------------------------------------------------------------------
	logic             valid_s1;
	logic             op_s1;
	logic [IDX_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;

	logic out_valid_q;
	logic adv;
	logic take;

	// lookup finishes when the response register is free or being drained
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= req.opcode;
			set_s1 <= set_in;
			tag_s1 <= tag_in;
		end
	end

	// ------------------------------------------------------------------
	// Tag RAM, one row per set, all ways side by side
	// ------------------------------------------------------------------
	logic                           ram_we;
	logic [IDX_W-1:0]               ram_raddr;
	logic [sac_nru_pkg::LINE_W-1:0] ram_rdata;
	sac_nru_pkg::set_line_t         new_line;

	// while held, re-read the same set so read data stays current
	assign ram_raddr = req.ready ? set_in : set_s1;

	sac_nru_ram #(
		.WIDTH (sac_nru_pkg::LINE_W),
		.DEPTH (NUM_SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (set_s1),
		.wdata (new_line),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Written flag per set: an unwritten set reads as its reset contents.
	logic [NUM_SETS-1:0]    set_written_q;
	// Last write, forwarded to a following request on the same set.
	logic                   fwd_valid_q;
	logic [IDX_W-1:0]       fwd_set_q;
	sac_nru_pkg::set_line_t fwd_line_q;

	sac_nru_pkg::set_line_t cur_line;
	logic [NUM_WAYS-1:0]    way_match;
	logic                   lookup_hit;
	logic                   nru_any;
	logic [WAY_W-1:0]       hit_way;
	logic [WAY_W-1:0]       victim_way;
	logic [WAY_W-1:0]       res_way;

	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_nxt;
	logic [CNT_W-1:0] hit_cnt_nxt;

	always_comb begin
		if (!set_written_q[set_s1]) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				cur_line[w].valid = 1'b0;
				cur_line[w].tag   = '0;
				cur_line[w].nru   = 1'b1;
			end
		end else if (fwd_valid_q && (fwd_set_q == set_s1)) begin
			cur_line = fwd_line_q;
		end else begin
			cur_line = sac_nru_pkg::set_line_t'(ram_rdata);
		end

		for (int w = 0; w < NUM_WAYS; w++) begin
			way_match[w] = cur_line[w].valid && (cur_line[w].tag == tag_s1);
		end
		lookup_hit = |way_match;

		// lowest matching way, lowest NRU-set way
		hit_way    = '0;
		victim_way = '0;
		nru_any    = 1'b0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (way_match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (cur_line[w].nru) begin
				victim_way = WAY_W'(w);
				nru_any    = 1'b1;
			end
		end

		new_line = cur_line;
		if (lookup_hit) begin
			res_way               = hit_way;
			new_line[hit_way].nru = 1'b0;
		end else begin
			// no NRU bit set: set them all, fill way 0 (victim_way is 0 here)
			if (!nru_any) begin
				for (int w = 0; w < NUM_WAYS; w++) begin
					new_line[w].nru = 1'b1;
				end
			end
			res_way                    = victim_way;
			new_line[victim_way].valid = 1'b1;
			new_line[victim_way].tag   = tag_s1;
			new_line[victim_way].nru   = 1'b0;
		end

		hit_cnt_nxt  = hit_cnt_q;
		miss_cnt_nxt = miss_cnt_q;
		if (lookup_hit) begin
			if (hit_cnt_q != sac_nru_pkg::CNT_MAX) begin
				hit_cnt_nxt = hit_cnt_q + CNT_W'(1);
			end
		end else begin
			if (miss_cnt_q != sac_nru_pkg::CNT_MAX) begin
				miss_cnt_nxt = miss_cnt_q + CNT_W'(1);
			end
		end
	end

	assign ram_we = adv && (op_s1 == sac_nru_pkg::OP_ACCESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_written_q <= '0;
			fwd_valid_q   <= 1'b0;
			miss_cnt_q    <= '0;
			hit_cnt_q     <= '0;
		end else if (adv) begin
			if (op_s1 == sac_nru_pkg::OP_CLEAR) begin
				set_written_q <= '0;
				fwd_valid_q   <= 1'b0;
				miss_cnt_q    <= '0;
				hit_cnt_q     <= '0;
			end else begin
				set_written_q[set_s1] <= 1'b1;
				fwd_valid_q           <= 1'b1;
				miss_cnt_q            <= miss_cnt_nxt;
				hit_cnt_q             <= hit_cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_set_q  <= set_s1;
			fwd_line_q <= new_line;
		end
	end

	// ------------------------------------------------------------------
	// Response register
	// ------------------------------------------------------------------
	logic             hit_q;
	logic [WAY_W-1:0] way_q;
	logic [IDX_W-1:0] set_q;
	logic [CNT_W-1:0] miss_tot_q;
	logic [CNT_W-1:0] hit_tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (op_s1 == sac_nru_pkg::OP_CLEAR) begin
				hit_q      <= 1'b0;
				way_q      <= '0;
				set_q      <= '0;
				miss_tot_q <= '0;
				hit_tot_q  <= '0;
			end else begin
				hit_q      <= lookup_hit;
				way_q      <= res_way;
				set_q      <= set_s1;
				miss_tot_q <= miss_cnt_nxt;
				hit_tot_q  <= hit_cnt_nxt;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.way        = way_q;
	assign rsp.set_index  = set_q;
	assign rsp.miss_total = miss_tot_q;
	assign rsp.hit_total  = hit_tot_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SAC_NRU_ASSERT_NXT(a_clear_resets, clk, arst_n,
		adv && (op_s1 == sac_nru_pkg::OP_CLEAR),
		(miss_cnt_q == '0) && (hit_cnt_q == '0) && (set_written_q == '0) && !fwd_valid_q,
		"clear left state behind")
	`SAC_NRU_ASSERT_NXT(a_write_marks_set, clk, arst_n, ram_we,
		set_written_q[$past(set_s1)] && fwd_valid_q && (fwd_set_q == $past(set_s1)),
		"written set not flagged or forwarded")
	`SAC_NRU_ASSERT_NXT(a_hit_count, clk, arst_n,
		ram_we && lookup_hit && (hit_cnt_q != sac_nru_pkg::CNT_MAX),
		(hit_cnt_q == $past(hit_cnt_q) + CNT_W'(1)) && (miss_cnt_q == $past(miss_cnt_q)),
		"hit count did not step")
	`SAC_NRU_ASSERT_IMP(a_no_idle_write, clk, arst_n, ram_we,
		valid_s1 && (!out_valid_q || rsp.ready),
		"tag RAM written without a finishing lookup")

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Set-associative cache NRU unit: self-checking testbench
// Drives access and clear requests under a series of offset/index register
// settings and checks every response against typed-in values or a cycle-free
// shadow of the tag store, NRU bits and saturating hit/miss totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import sac_nru_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PER_CFG = 114;
	localparam int POOL_SIZE     = 16;
	localparam int NUM_GEOMS     = 10;
	localparam int MAX_PRINTS    = 20;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
		logic [IDX_W-1:0] set_index;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] hit_total;
	} lookup_rsp_t;

	typedef struct {
		op_t                  op;
		logic [ADDR_BITS-1:0] addr;
		bit                   known;  // response typed in below, else predicted
		lookup_rsp_t          rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic rsp_take = 1'b0;

	sac_nru_in_if  req_ch ();
	sac_nru_out_if rsp_ch ();

	assign rsp_ch.ready = rsp_take;

	set_assoc_cache_nru_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the tag store, indexed [set][way]
	logic                 shadow_valid [NUM_SETS][NUM_WAYS];
	logic [ADDR_BITS-1:0] shadow_tag   [NUM_SETS][NUM_WAYS];
	logic                 shadow_nru   [NUM_SETS][NUM_WAYS];
	logic [CNT_W-1:0]     shadow_misses;
	logic [CNT_W-1:0]     shadow_hits;
	logic [CFG_W-1:0]     shadow_offset;
	logic [CFG_W-1:0]     shadow_index_low;

	// Responses still owed by the DUT, oldest first
	lookup_rsp_t lookup_results_q [$];
	stim_row_t   directed_q [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int rsp_count      = 0;
	int cycle_count    = 0;
	int n_hits         = 0;
	int n_misses       = 0;
	int n_clears       = 0;
	int n_geoms        = 0;

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: the slowest legal run is far below this
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses owed", cycle_count,
				lookup_results_q.size());
			$display("[set_assoc_cache_nru_unit] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < MAX_PRINTS)
			$display("MISMATCH %s: got 0x%0h want 0x%0h (response %0d, t=%0t)",
				what, got, want, rsp_count, $realtime);
		mismatch_count++;
	endtask

	// Clear request and reset both leave every line invalid with NRU set
	function automatic void clear_shadow();
		for (int s = 0; s < NUM_SETS; s++) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				shadow_valid[s][w] = 1'b0;
				shadow_tag[s][w]   = '0;
				shadow_nru[s][w]   = 1'b1;
			end
		end
		shadow_misses = '0;
		shadow_hits   = '0;
	endfunction

	// Lookup and update of the shadow store for one accepted request.
	// Index field: IDX_W bits from index_low, bits past the address read 0.
	// Tag: address bits from offset_bits up, index field squeezed out.
	task automatic predict_lookup(input op_t op, input logic [ADDR_BITS-1:0] addr,
		output lookup_rsp_t r);
		logic [2*ADDR_BITS-1:0] wide;
		logic [IDX_W-1:0]       set_sel;
		logic [ADDR_BITS-1:0]   tag;
		int p;
		int lo;
		int hit_way;
		int fill_way;

		r = '0;
		if (op == OP_CLEAR) begin
			clear_shadow();
			n_clears++;
			return;
		end

		lo      = int'(shadow_index_low);
		wide    = {{ADDR_BITS{1'b0}}, addr} >> shadow_index_low;
		set_sel = wide[IDX_W-1:0];
		tag     = '0;
		p       = 0;
		for (int b = int'(shadow_offset); b < ADDR_BITS; b++) begin
			if (b < lo || b >= lo + IDX_W) begin
				tag[p] = addr[b];
				p++;
			end
		end

		// lowest matching way wins if a register change left duplicates
		hit_way = -1;
		for (int w = NUM_WAYS - 1; w >= 0; w--)
			if (shadow_valid[set_sel][w] && shadow_tag[set_sel][w] == tag)
				hit_way = w;

		if (hit_way >= 0) begin
			shadow_nru[set_sel][hit_way] = 1'b0;
			if (shadow_hits != CNT_MAX)
				shadow_hits++;
			r.hit = 1'b1;
			r.way = WAY_W'(hit_way);
			n_hits++;
		end else begin
			fill_way = -1;
			for (int w = NUM_WAYS - 1; w >= 0; w--)
				if (shadow_nru[set_sel][w])
					fill_way = w;
			// no NRU candidate: set all bits again and take way 0
			if (fill_way < 0) begin
				for (int w = 0; w < NUM_WAYS; w++)
					shadow_nru[set_sel][w] = 1'b1;
				fill_way = 0;
			end
			shadow_valid[set_sel][fill_way] = 1'b1;
			shadow_tag[set_sel][fill_way]   = tag;
			shadow_nru[set_sel][fill_way]   = 1'b0;
			if (shadow_misses != CNT_MAX)
				shadow_misses++;
			r.hit = 1'b0;
			r.way = WAY_W'(fill_way);
			n_misses++;
		end
		r.set_index  = set_sel;
		r.miss_total = shadow_misses;
		r.hit_total  = shadow_hits;
	endtask

	// Present one request, hold it until the DUT takes it, then predict.
	// Any gap before it comes from the sender idle rate.
	task automatic send_request(input op_t op, input logic [ADDR_BITS-1:0] addr,
		output lookup_rsp_t predicted);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= op;
		req_ch.address <= addr;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predict_lookup(op, addr, predicted);
	endtask

	// Registers change only with nothing in flight, so wait until the last
	// response is in before returning.
	task automatic wait_drained();
		while (lookup_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_geometry(input logic [CFG_W-1:0] offset,
		input logic [CFG_W-1:0] index_low);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_OFFSET_BITS;
		cfg_wdata <= offset;
		@(posedge clk);
		cfg_index <= CFG_INDEX_LOW;
		cfg_wdata <= index_low;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_offset    = offset;
		shadow_index_low = index_low;
		n_geoms++;
	endtask

	task automatic set_idle_mode(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 48;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 48;
			end
			default: begin
				send_idle_pct  = 22;
				recv_stall_pct = 22;
			end
		endcase
	endtask

	task automatic add_row(input op_t op, input logic [ADDR_BITS-1:0] addr,
		input bit known, input int hit, input int way, input int set_sel,
		input int misses, input int hits);
		stim_row_t row;
		row.op             = op;
		row.addr           = addr;
		row.known          = known;
		row.rsp.hit        = hit[0];
		row.rsp.way        = WAY_W'(way);
		row.rsp.set_index  = IDX_W'(set_sel);
		row.rsp.miss_total = CNT_W'(misses);
		row.rsp.hit_total  = CNT_W'(hits);
		directed_q.push_back(row);
	endtask

	// Response side: random backpressure, in-order compare
	always @(posedge clk) begin : rsp_monitor
		lookup_rsp_t want;
		rsp_take <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (lookup_results_q.size() == 0) begin
				report_mismatch("response with none owed", 32'(rsp_ch.set_index), 0);
			end else begin
				want = lookup_results_q.pop_front();
				if (rsp_ch.hit !== want.hit)
					report_mismatch("hit", 32'(rsp_ch.hit), 32'(want.hit));
				if (rsp_ch.way !== want.way)
					report_mismatch("way", 32'(rsp_ch.way), 32'(want.way));
				if (rsp_ch.set_index !== want.set_index)
					report_mismatch("set_index", 32'(rsp_ch.set_index),
						32'(want.set_index));
				if (rsp_ch.miss_total !== want.miss_total)
					report_mismatch("miss_total", 32'(rsp_ch.miss_total),
						32'(want.miss_total));
				if (rsp_ch.hit_total !== want.hit_total)
					report_mismatch("hit_total", 32'(rsp_ch.hit_total),
						32'(want.hit_total));
			end
			rsp_count++;
		end
	end

	// Register settings walked by the random phases: extremes, an index field
	// partly past bit 31, and a return to the reset values.
	logic [CFG_W-1:0] geom_offset [NUM_GEOMS] = '{0, 16, 31, 4, 0, 31, 2, 8, 17, 1};
	logic [CFG_W-1:0] geom_index  [NUM_GEOMS] = '{0, 26, 31, 10, 31, 0, 2, 20, 27, 5};

	initial begin : stimulus
		lookup_rsp_t predicted;
		stim_row_t row;
		logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
		logic [ADDR_BITS-1:0] addr;
		op_t op;
		int pick;
		int k;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_OFFSET_BITS;
		cfg_wdata      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_ACCESS;
		req_ch.address <= '0;

		clear_shadow();
		shadow_offset    = OFFSET_BITS_RST;
		shadow_index_low = INDEX_LOW_RST;

		// Directed part, reset geometry (offset 2, index field bits 7:2).
		// Fill set 0 through all four ways, then force the all-clear NRU
		// wrap, then a clear request in the middle of traffic.
		add_row(OP_ACCESS, 32'h0000_0000, 1, 0, 0, 0, 1, 0);
		add_row(OP_ACCESS, 32'h0000_0000, 1, 1, 0, 0, 1, 1);
		add_row(OP_ACCESS, 32'hFFFF_FFFF, 1, 0, 0, 63, 2, 1);
		add_row(OP_ACCESS, 32'hFFFF_FFFF, 1, 1, 0, 63, 2, 2);
		add_row(OP_ACCESS, 32'h0000_0100, 1, 0, 1, 0, 3, 2);
		add_row(OP_ACCESS, 32'h0000_0200, 1, 0, 2, 0, 4, 2);
		add_row(OP_ACCESS, 32'h0000_0300, 1, 0, 3, 0, 5, 2);
		add_row(OP_ACCESS, 32'h0000_0400, 1, 0, 0, 0, 6, 2); // no NRU way left
		add_row(OP_ACCESS, 32'h0000_0000, 1, 0, 1, 0, 7, 2);
		add_row(OP_ACCESS, 32'h0000_0003, 1, 1, 1, 0, 7, 3); // offset bits only
		add_row(OP_CLEAR,  32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0);
		add_row(OP_ACCESS, 32'h0000_0000, 1, 0, 0, 0, 1, 0);
		add_row(OP_ACCESS, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
		add_row(OP_ACCESS, 32'h5555_5555, 0, 0, 0, 0, 0, 0);
		add_row(OP_ACCESS, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0);
		add_row(OP_ACCESS, 32'h0000_00FC, 0, 0, 0, 0, 0, 0);
		add_row(OP_ACCESS, 32'h7FFF_FFFC, 0, 0, 0, 0, 0, 0);
		add_row(OP_ACCESS, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
		add_row(OP_CLEAR,  32'h0000_0000, 1, 0, 0, 0, 0, 0);
		add_row(OP_ACCESS, 32'hFFFF_FFFF, 1, 0, 0, 63, 1, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle_mode(IDLE_NONE);
		foreach (directed_q[i]) begin
			row = directed_q[i];
			send_request(row.op, row.addr, predicted);
			lookup_results_q.push_back(row.known ? row.rsp : predicted);
		end
		req_ch.valid <= 1'b0;

		// Random part. Lines stay across register changes on purpose, so
		// stale tags get looked up under the new mapping.
		for (int g = 0; g < NUM_GEOMS; g++) begin
			wait_drained();
			apply_geometry(geom_offset[g], geom_index[g]);
			set_idle_mode(idle_mode_t'(g % 4));
			for (int i = 0; i < POOL_SIZE; i++)
				addr_pool[i] = $urandom();

			for (int n = 0; n < RANDOM_PER_CFG; n++) begin
				pick = $urandom_range(99);
				k    = $urandom_range(POOL_SIZE - 1);
				op   = OP_ACCESS;
				if (pick < 4) begin
					op   = OP_CLEAR;
					addr = $urandom();
				end else if (pick < 60) begin
					// reuse, mostly hits; low-bit jitter may cross offset
					addr = addr_pool[k] ^ ADDR_BITS'($urandom_range(3));
				end else if (pick < 85) begin
					// one flipped bit: same line, same set with a new tag, or another set
					addr = addr_pool[k] ^ (ADDR_BITS'(1) << $urandom_range(ADDR_BITS - 1));
					addr_pool[$urandom_range(POOL_SIZE - 1)] = addr;
				end else begin
					addr         = $urandom();
					addr_pool[k] = addr;
				end
				send_request(op, addr, predicted);
				lookup_results_q.push_back(predicted);
			end
			req_ch.valid <= 1'b0;
		end

		// Drain, then a short tail to catch stray responses
		while (lookup_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests checked over %0d register settings", rsp_count, n_geoms);
		$display("predicted %0d hits, %0d misses, %0d clears; %0d mismatches",
			n_hits, n_misses, n_clears, mismatch_count);
		if (mismatch_count == 0 && lookup_results_q.size() == 0) begin
			$display("[set_assoc_cache_nru_unit] OK");
		end else begin
			$display("[set_assoc_cache_nru_unit] ERROR");
		end
		$finish;
	end

endmodule
